>>> rtl/art_pkg.sv
// Shared types and constants of the acknowledgement retransmit table.
package art_pkg;

   localparam int TABLE_ENTRIES_DEFAULT = 8;
   localparam int MAX_RESULTS           = 8;
   localparam int QUEUE_DEPTH           = 2;

   localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
   localparam logic [7:0]  ATTEMPT_MAX   = 8'd255;
   localparam logic [7:0]  ATTEMPT_FIRST = 8'd1;

   // Command codes on the request channel
   localparam logic [1:0] CMD_RECORD = 2'd0;
   localparam logic [1:0] CMD_ACK    = 2'd1;
   localparam logic [1:0] CMD_TICK   = 2'd2;

   typedef enum logic [1:0] {
      OP_RECORD,
      OP_ACK,
      OP_TICK
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      logic [31:0] now_ms;
      logic [7:0]  src_id;
      logic [7:0]  dst_id;
      logic [15:0] crc;
      logic [7:0]  packet_ref;
   } op_type;

   typedef struct packed {
      logic [2:0]  slot;
      logic [7:0]  pkt_ref;
      logic [7:0]  src;
      logic [7:0]  dst;
      logic [15:0] crc;
      logic [7:0]  attempt;
   } resend_type;

endpackage

>>> rtl/art_front.sv
// Front end: classifies request items and queues the ones that do work.
module art_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_cmd,
   input  logic [31:0]         req_now_ms,
   input  logic [7:0]          req_src_id,
   input  logic [7:0]          req_dst_id,
   input  logic [15:0]         req_crc,
   input  logic                req_ack_requested,
   input  logic [7:0]          req_packet_ref,
   output logic                q_valid,
   input  logic                q_pop,
   output art_pkg::op_type     q_op
);

   localparam int PTR_W = (art_pkg::QUEUE_DEPTH > 1) ? $clog2(art_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(art_pkg::QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(art_pkg::QUEUE_DEPTH);

   art_pkg::op_type   queue_ff [art_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   art_pkg::op_type   op_new;
   logic              keep;
   logic              push;
   logic              pop;

   // Decode the command; drop records without ack request and unknown codes
   always_comb begin
      keep        = 1'b0;
      op_new.kind = art_pkg::OP_TICK;
      unique case (req_cmd)
         art_pkg::CMD_RECORD: begin
            keep        = req_ack_requested;
            op_new.kind = art_pkg::OP_RECORD;
         end
         art_pkg::CMD_ACK: begin
            keep        = 1'b1;
            op_new.kind = art_pkg::OP_ACK;
         end
         art_pkg::CMD_TICK: begin
            keep        = 1'b1;
            op_new.kind = art_pkg::OP_TICK;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
      op_new.now_ms     = req_now_ms;
      op_new.src_id     = req_src_id;
      op_new.dst_id     = req_dst_id;
      op_new.crc        = req_crc;
      op_new.packet_ref = req_packet_ref;
   end

   assign req_stall = (count_ff == FULL_COUNT);
   assign q_valid   = (count_ff != '0);
   assign q_op      = queue_ff[rd_ptr_ff];
   assign push      = req_valid && !req_stall && keep;
   assign pop       = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         queue_ff[wr_ptr_ff] <= op_new;
      end
   end

endmodule

>>> rtl/art_engine.sv
// Back end: table memories, record insert, and the ack and tick scan pipeline.
module art_engine #(
   parameter int TABLE_ENTRIES = art_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [15:0]          timeout,
   input  logic                 q_valid,
   output logic                 q_pop,
   input  art_pkg::op_type      q_op,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output art_pkg::resend_type  rsp_data,
   output logic                 rsp_last
);

   localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
   localparam int EMIT_W = $clog2(art_pkg::MAX_RESULTS + 1);
   localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
   localparam logic [CNT_W-1:0]  SCAN_LEN = CNT_W'(TABLE_ENTRIES);
   localparam logic [EMIT_W-1:0] EMIT_CAP = EMIT_W'(art_pkg::MAX_RESULTS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN
   } state_type;

   // Table memories, addressed by physical slot
   logic [31:0] expiry_mem_ff  [TABLE_ENTRIES];
   logic [7:0]  attempt_mem_ff [TABLE_ENTRIES];
   logic [7:0]  src_mem_ff     [TABLE_ENTRIES];
   logic [7:0]  dst_mem_ff     [TABLE_ENTRIES];
   logic [15:0] crc_mem_ff     [TABLE_ENTRIES];
   logic [7:0]  ref_mem_ff     [TABLE_ENTRIES];

   logic [31:0] rd_expiry_ff;
   logic [7:0]  rd_attempt_ff;
   logic [7:0]  rd_src_ff;
   logic [7:0]  rd_dst_ff;
   logic [15:0] rd_crc_ff;
   logic [7:0]  rd_ref_ff;

   state_type               state_ff, state_in;
   logic [IDX_W-1:0]        head_ff, head_in;
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   art_pkg::op_type         op_ff, op_in;
   logic [CNT_W-1:0]        issue_cnt_ff, issue_cnt_in;
   logic [IDX_W-1:0]        rd_addr_ff, rd_addr_in;
   logic [EMIT_W-1:0]       emit_cnt_ff, emit_cnt_in;

   logic                    s1_valid_ff, s1_valid_in;
   logic [IDX_W-1:0]        s1_addr_ff, s1_addr_in;
   logic [2:0]              s1_slot_ff, s1_slot_in;

   logic                    s2_valid_ff, s2_valid_in;
   logic                    s2_hit_ff, s2_hit_in;
   logic [IDX_W-1:0]        s2_addr_ff, s2_addr_in;
   logic [23:0]             s2_prod_ff, s2_prod_in;
   art_pkg::resend_type     s2_info_ff, s2_info_in;

   logic                    pend_valid_ff, pend_valid_in;
   art_pkg::resend_type     pend_ff, pend_in;

   logic                    out_valid_ff, out_valid_in;
   art_pkg::resend_type     out_ff, out_in;
   logic                    out_last_ff, out_last_in;

   logic                    take;
   logic                    rec;
   logic [IDX_W-1:0]        new_head;
   logic                    out_free;
   logic                    s2_emit;
   logic                    adv;
   logic                    issuing;
   logic                    s1_live;
   logic                    s1_expired;
   logic                    s1_match;
   logic [23:0]             product;
   logic [7:0]              next_attempt;

   logic                    meta_we;
   logic [IDX_W-1:0]        meta_addr;
   logic [31:0]             meta_expiry;
   logic [7:0]              meta_attempt;

   assign take     = (state_ff == ST_IDLE) && q_valid;
   assign q_pop    = take;
   assign rec      = take && (q_op.kind == art_pkg::OP_RECORD);
   assign new_head = (head_ff == '0) ? LAST_IDX : head_ff - 1'b1;
   assign out_free = !out_valid_ff || !rsp_stall;
   assign s2_emit  = s2_valid_ff && s2_hit_ff && (op_ff.kind == art_pkg::OP_TICK) &&
                     (emit_cnt_ff != EMIT_CAP);
   // Freeze the whole pipeline while a hit cannot push the pending result out
   assign adv      = !(s2_emit && pend_valid_ff && !out_free);
   assign issuing  = (state_ff == ST_SCAN) && (issue_cnt_ff != SCAN_LEN) && adv;

   // Stage 1 evaluation on registered read data
   always_comb begin
      s1_live      = valid_ff[s1_addr_ff];
      s1_expired   = s1_live && (rd_expiry_ff < op_ff.now_ms);
      s1_match     = s1_live && (rd_dst_ff == op_ff.src_id) && (rd_src_ff == op_ff.dst_id) &&
                     (rd_crc_ff == op_ff.crc);
      product      = timeout * rd_attempt_ff;
      next_attempt = (rd_attempt_ff == art_pkg::ATTEMPT_MAX) ? art_pkg::ATTEMPT_MAX
                                                             : rd_attempt_ff + 8'd1;
   end

   // Metadata write port: record insert or tick write-back
   always_comb begin
      if (rec) begin
         meta_we      = 1'b1;
         meta_addr    = new_head;
         meta_expiry  = q_op.now_ms + 32'(timeout);
         meta_attempt = art_pkg::ATTEMPT_FIRST;
      end else begin
         meta_we      = adv && s2_emit;
         meta_addr    = s2_addr_ff;
         meta_expiry  = op_ff.now_ms + 32'(s2_prod_ff);
         meta_attempt = s2_info_ff.attempt;
      end
   end

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      valid_in      = valid_ff;
      op_in         = op_ff;
      issue_cnt_in  = issue_cnt_ff;
      rd_addr_in    = rd_addr_ff;
      emit_cnt_in   = emit_cnt_ff;
      s1_valid_in   = s1_valid_ff;
      s1_addr_in    = s1_addr_ff;
      s1_slot_in    = s1_slot_ff;
      s2_valid_in   = s2_valid_ff;
      s2_hit_in     = s2_hit_ff;
      s2_addr_in    = s2_addr_ff;
      s2_prod_in    = s2_prod_ff;
      s2_info_in    = s2_info_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      out_in        = out_ff;
      out_last_in   = out_last_ff;

      if (rec) begin
         head_in           = new_head;
         valid_in[new_head] = 1'b1;
      end

      // Advance the scan pipeline
      if (adv) begin
         s1_valid_in = issuing;
         if (issuing) begin
            s1_addr_in   = rd_addr_ff;
            s1_slot_in   = 3'(issue_cnt_ff);
            rd_addr_in   = (rd_addr_ff == LAST_IDX) ? '0 : rd_addr_ff + 1'b1;
            issue_cnt_in = issue_cnt_ff + 1'b1;
         end
         s2_valid_in = s1_valid_ff;
         s2_hit_in   = (op_ff.kind == art_pkg::OP_TICK) ? s1_expired : s1_match;
         s2_addr_in  = s1_addr_ff;
         s2_prod_in  = product;
         s2_info_in.slot    = s1_slot_ff;
         s2_info_in.pkt_ref = rd_ref_ff;
         s2_info_in.src     = rd_src_ff;
         s2_info_in.dst     = rd_dst_ff;
         s2_info_in.crc     = rd_crc_ff;
         s2_info_in.attempt = next_attempt;

         // Acknowledged entry: free the slot
         if (s2_valid_ff && s2_hit_ff && (op_ff.kind == art_pkg::OP_ACK)) begin
            valid_in[s2_addr_ff] = 1'b0;
         end

         // Retransmission: hold it pending until we know whether it ends the run
         if (s2_emit) begin
            if (pend_valid_ff) begin
               out_valid_in = 1'b1;
               out_in       = pend_ff;
               out_last_in  = 1'b0;
            end
            pend_valid_in = 1'b1;
            pend_in       = s2_info_ff;
            emit_cnt_in   = emit_cnt_ff + 1'b1;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (take && (q_op.kind != art_pkg::OP_RECORD)) begin
               state_in     = ST_SCAN;
               op_in        = q_op;
               issue_cnt_in = '0;
               rd_addr_in   = head_ff;
               emit_cnt_in  = '0;
            end
         end
         ST_SCAN: begin
            if ((issue_cnt_ff == SCAN_LEN) && !s1_valid_ff && !s2_valid_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_valid_in  = 1'b1;
               out_in        = pend_ff;
               out_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         valid_ff      <= '0;
         issue_cnt_ff  <= '0;
         emit_cnt_ff   <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         valid_ff      <= valid_in;
         issue_cnt_ff  <= issue_cnt_in;
         emit_cnt_ff   <= emit_cnt_in;
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s2_valid_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      op_ff       <= op_in;
      rd_addr_ff  <= rd_addr_in;
      s1_addr_ff  <= s1_addr_in;
      s1_slot_ff  <= s1_slot_in;
      s2_hit_ff   <= s2_hit_in;
      s2_addr_ff  <= s2_addr_in;
      s2_prod_ff  <= s2_prod_in;
      s2_info_ff  <= s2_info_in;
      pend_ff     <= pend_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   // Metadata memory
   always_ff @(posedge clock) begin
      if (meta_we) begin
         expiry_mem_ff[meta_addr]  <= meta_expiry;
         attempt_mem_ff[meta_addr] <= meta_attempt;
      end
      if (issuing) begin
         rd_expiry_ff  <= expiry_mem_ff[rd_addr_ff];
         rd_attempt_ff <= attempt_mem_ff[rd_addr_ff];
      end
   end

   // Packet memory, written on record only
   always_ff @(posedge clock) begin
      if (rec) begin
         src_mem_ff[new_head] <= q_op.src_id;
         dst_mem_ff[new_head] <= q_op.dst_id;
         crc_mem_ff[new_head] <= q_op.crc;
         ref_mem_ff[new_head] <= q_op.packet_ref;
      end
      if (issuing) begin
         rd_src_ff <= src_mem_ff[rd_addr_ff];
         rd_dst_ff <= dst_mem_ff[rd_addr_ff];
         rd_crc_ff <= crc_mem_ff[rd_addr_ff];
         rd_ref_ff <= ref_mem_ff[rd_addr_ff];
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;
   assign rsp_last  = out_last_ff;

endmodule

>>> rtl/ack_retransmit_table.sv
// Top level of the acknowledgement retransmit table.
//
// Keeps up to TABLE_ENTRIES sent packets awaiting acknowledgement in a ring
// of memories with separate read and write ports and a head pointer; slot 0
// is the newest packet. A record item (command 0 with ack_requested set) is
// done without leaving the idle state: it moves the head back one slot,
// overwriting the oldest entry, and writes the packet with expiry now plus
// the timeout and attempt count 1. An acknowledgement and a tick each walk
// the table through a three-stage read / evaluate / write-back pipeline, one
// slot per cycle unless the result side freezes it; the engine takes no new
// item until the walk and its last result are done. The single memory read
// port sets that rate. A tick emits one result per expired active slot in
// slot order, at most eight per tick, and flags the final one with
// last_of_run; each emitted slot gets a new expiry of now plus timeout times
// its old attempt count, and its count goes up to at most 255. The front
// queue holds two items, so requests are still taken while the engine works
// until it is full; records without an ack request and unknown commands are
// dropped at the front. The timeout register resets to 1000 ms; write it
// only while the block is idle. The result register lets the engine keep
// scanning while a finished result waits to be taken, until the next hit.
module ack_retransmit_table #(
   parameter int TABLE_ENTRIES = art_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [31:0] req_now_ms,
   input  logic [7:0]  req_src_id,
   input  logic [7:0]  req_dst_id,
   input  logic [15:0] req_crc,
   input  logic        req_ack_requested,
   input  logic [7:0]  req_packet_ref,
   // Result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_resend_slot,
   output logic [7:0]  rsp_resend_ref,
   output logic [7:0]  rsp_resend_src,
   output logic [7:0]  rsp_resend_dst,
   output logic [15:0] rsp_resend_crc,
   output logic [7:0]  rsp_resend_attempt,
   output logic        rsp_last_of_run,
   // Timeout register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_retry_timeout_ms
);

   logic [15:0]          retry_timeout_ff, retry_timeout_in;
   logic                 q_valid;
   logic                 q_pop;
   art_pkg::op_type      q_op;
   art_pkg::resend_type  rsp_data;

   // Always ready for a register write
   assign csr_ready = 1'b1;

   // Load the base timeout on a completed write
   assign retry_timeout_in = (csr_valid && csr_ready) ? csr_retry_timeout_ms : retry_timeout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         retry_timeout_ff <= art_pkg::TIMEOUT_RESET;
      end else begin
         retry_timeout_ff <= retry_timeout_in;
      end
   end

   // Front: classify and queue
   art_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_now_ms        (req_now_ms),
      .req_src_id        (req_src_id),
      .req_dst_id        (req_dst_id),
      .req_crc           (req_crc),
      .req_ack_requested (req_ack_requested),
      .req_packet_ref    (req_packet_ref),
      .q_valid           (q_valid),
      .q_pop             (q_pop),
      .q_op              (q_op)
   );

   // Back: table and scan engine
   art_engine #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .timeout   (retry_timeout_ff),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_op      (q_op),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .rsp_last  (rsp_last_of_run)
   );

   // Split the result record onto its ports
   assign rsp_resend_slot    = rsp_data.slot;
   assign rsp_resend_ref     = rsp_data.pkt_ref;
   assign rsp_resend_src     = rsp_data.src;
   assign rsp_resend_dst     = rsp_data.dst;
   assign rsp_resend_crc     = rsp_data.crc;
   assign rsp_resend_attempt = rsp_data.attempt;

endmodule

>>> rtl/art_checker.sv
// Port-level assertions for the acknowledgement retransmit table.
module art_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_resend_slot,
   input logic [7:0]  rsp_resend_attempt,
   input logic        rsp_last_of_run
);

   // Reset leaves no result on the port
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_resend_slot) &&
      $stable(rsp_resend_attempt) && $stable(rsp_last_of_run))
      else $error("stalled result changed");

   // A retransmission is at least the second attempt
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_resend_attempt >= 8'd2)
      else $error("retransmission with attempt count below two");

endmodule

bind ack_retransmit_table art_checker u_art_checker (.*);
